// ===== rtl/beaver_share_multiplier_macros.svh =====
// Assertion macros for the Beaver share multiplier.
`ifndef BEAVER_SHARE_MULTIPLIER_MACROS_SVH
`define BEAVER_SHARE_MULTIPLIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bsm_pkg.sv =====
// Shared constants and modular helpers for the Beaver share multiplier.
package bsm_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned OutW    = 63;
  localparam int unsigned NumOps  = 10;
  localparam int unsigned NumLane = 5;
  localparam logic [DataW-1:0] ModLimit = {1'b1, {(DataW-1){1'b0}}};

  // a, b below m, m at most 2^63: the sum cannot wrap
  function automatic logic [DataW-1:0] madd(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                            logic [DataW-1:0] m);
    logic [DataW-1:0] s;
    s = a + b;
    return (s >= m) ? s - m : s;
  endfunction

  function automatic logic [DataW-1:0] msub(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                            logic [DataW-1:0] m);
    return (a >= b) ? a - b : m - (b - a);
  endfunction

endpackage

// ===== rtl/bsm_red_cell.sv =====
// One restoring-reduction step: takes the next operand bit into the remainder.
module bsm_red_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bsm_pkg::DataW-1:0] mod_i,
  input  logic [bsm_pkg::DataW-1:0] rem_i,
  input  logic [bsm_pkg::DataW-1:0] val_i,
  output logic [bsm_pkg::DataW-1:0] rem_o,
  output logic [bsm_pkg::DataW-1:0] val_o
);
  import bsm_pkg::*;

  logic [DataW-1:0] rem_d, rem_q, val_q, shf;

  // remainder stays below 2^63, so the doubled value fits
  assign shf   = {rem_i[DataW-2:0], val_i[DataW-1]};
  assign rem_d = (shf >= mod_i) ? shf - mod_i : shf;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      val_q <= {val_i[DataW-2:0], 1'b0};
    end
  end

  assign rem_o = rem_q;
  assign val_o = val_q;
endmodule

// ===== rtl/bsm_mul_cell.sv =====
// One double-and-add step of a modular product, multiplier msb first.
module bsm_mul_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bsm_pkg::DataW-1:0] mod_i,
  input  logic [bsm_pkg::DataW-1:0] acc_i,
  input  logic [bsm_pkg::DataW-1:0] mcand_i,
  input  logic [bsm_pkg::DataW-1:0] mplier_i,
  output logic [bsm_pkg::DataW-1:0] acc_o,
  output logic [bsm_pkg::DataW-1:0] mcand_o,
  output logic [bsm_pkg::DataW-1:0] mplier_o
);
  import bsm_pkg::*;

  logic [DataW-1:0] acc_d, acc_q, mcand_q, mplier_q, dbl;

  assign dbl   = madd(acc_i, acc_i, mod_i);
  assign acc_d = mplier_i[DataW-1] ? madd(dbl, mcand_i, mod_i) : dbl;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q    <= acc_d;
      mcand_q  <= mcand_i;
      mplier_q <= {mplier_i[DataW-2:0], 1'b0};
    end
  end

  assign acc_o    = acc_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;
endmodule

// ===== rtl/beaver_share_multiplier.sv =====
// Beaver-triple share multiplier: bit-serial cell chains, one request per cycle unless out_ready_i stalls the chain.
//
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_ready_o     | x, y, mask a/b, product c shares
//  out     | output    | out_valid_o / out_ready_i   | z_share_0_o, z_share_1_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o   | cfg_data_i (modulus)
//
// The chain has 64 reduction cells, one d/e stage, 64 multiply cells and two sum
// stages. One request enters per cycle when the output stage is free or being taken.
// A stall on out_ready_i freezes the whole chain. Reset clears valid bits; modulus is 1.
module beaver_share_multiplier (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bsm_pkg::DataW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bsm_pkg::DataW-1:0] x_share_0_i,
  input  logic [bsm_pkg::DataW-1:0] x_share_1_i,
  input  logic [bsm_pkg::DataW-1:0] y_share_0_i,
  input  logic [bsm_pkg::DataW-1:0] y_share_1_i,
  input  logic [bsm_pkg::DataW-1:0] mask_a_0_i,
  input  logic [bsm_pkg::DataW-1:0] mask_a_1_i,
  input  logic [bsm_pkg::DataW-1:0] mask_b_0_i,
  input  logic [bsm_pkg::DataW-1:0] mask_b_1_i,
  input  logic [bsm_pkg::DataW-1:0] product_c_0_i,
  input  logic [bsm_pkg::DataW-1:0] product_c_1_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bsm_pkg::OutW-1:0]  z_share_0_o,
  output logic [bsm_pkg::OutW-1:0]  z_share_1_o
);
  import bsm_pkg::*;
  `include "beaver_share_multiplier_macros.svh"

  localparam int unsigned NumStg = 2 * DataW + 3;

  logic             en;
  logic [DataW-1:0] mod_q;
  logic [NumStg-1:0] vld_q;

  logic [DataW-1:0] in_op  [NumOps];
  logic [DataW-1:0] red_r  [DataW][NumOps];
  logic [DataW-1:0] red_v  [DataW][NumOps];

  logic [DataW-1:0] d_q, e_q, a0_q, a1_q, b0_q, b1_q, c0_q, c1_q;
  logic [DataW-1:0] lane_a [NumLane];
  logic [DataW-1:0] lane_b [NumLane];
  logic [DataW-1:0] mul_acc [DataW][NumLane];
  logic [DataW-1:0] mul_a   [DataW][NumLane];
  logic [DataW-1:0] mul_b   [DataW][NumLane];
  logic [DataW-1:0] c0_dly_q [DataW];
  logic [DataW-1:0] c1_dly_q [DataW];
  logic [DataW-1:0] s0_q, s1_q, s2_q, s3_q, z0_q, z1_q;

  assign en          = !vld_q[NumStg-1] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // zero acts as 1, anything above 2^63 saturates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= DataW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_data_i == '0) begin
        mod_q <= DataW'(1);
      end else if (cfg_data_i > ModLimit) begin
        mod_q <= ModLimit;
      end else begin
        mod_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  assign in_op[0] = x_share_0_i;
  assign in_op[1] = x_share_1_i;
  assign in_op[2] = y_share_0_i;
  assign in_op[3] = y_share_1_i;
  assign in_op[4] = mask_a_0_i;
  assign in_op[5] = mask_a_1_i;
  assign in_op[6] = mask_b_0_i;
  assign in_op[7] = mask_b_1_i;
  assign in_op[8] = product_c_0_i;
  assign in_op[9] = product_c_1_i;

  for (genvar k = 0; k < DataW; k++) begin : g_red
    for (genvar l = 0; l < NumOps; l++) begin : g_op
      bsm_red_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .mod_i (mod_q),
        .rem_i ((k == 0) ? '0 : red_r[(k == 0) ? 0 : k-1][l]),
        .val_i ((k == 0) ? in_op[l] : red_v[(k == 0) ? 0 : k-1][l]),
        .rem_o (red_r[k][l]),
        .val_o (red_v[k][l])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q  <= msub(madd(red_r[DataW-1][0], red_r[DataW-1][1], mod_q),
                   madd(red_r[DataW-1][4], red_r[DataW-1][5], mod_q), mod_q);
      e_q  <= msub(madd(red_r[DataW-1][2], red_r[DataW-1][3], mod_q),
                   madd(red_r[DataW-1][6], red_r[DataW-1][7], mod_q), mod_q);
      a0_q <= red_r[DataW-1][4];
      a1_q <= red_r[DataW-1][5];
      b0_q <= red_r[DataW-1][6];
      b1_q <= red_r[DataW-1][7];
      c0_q <= red_r[DataW-1][8];
      c1_q <= red_r[DataW-1][9];
    end
  end

  // lanes: d*b0, e*a0, d*e, d*b1, e*a1
  assign lane_a[0] = d_q;  assign lane_b[0] = b0_q;
  assign lane_a[1] = e_q;  assign lane_b[1] = a0_q;
  assign lane_a[2] = d_q;  assign lane_b[2] = e_q;
  assign lane_a[3] = d_q;  assign lane_b[3] = b1_q;
  assign lane_a[4] = e_q;  assign lane_b[4] = a1_q;

  for (genvar k = 0; k < DataW; k++) begin : g_mul
    for (genvar l = 0; l < NumLane; l++) begin : g_lane
      bsm_mul_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (en),
        .mod_i    (mod_q),
        .acc_i    ((k == 0) ? '0 : mul_acc[(k == 0) ? 0 : k-1][l]),
        .mcand_i  ((k == 0) ? lane_a[l] : mul_a[(k == 0) ? 0 : k-1][l]),
        .mplier_i ((k == 0) ? lane_b[l] : mul_b[(k == 0) ? 0 : k-1][l]),
        .acc_o    (mul_acc[k][l]),
        .mcand_o  (mul_a[k][l]),
        .mplier_o (mul_b[k][l])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_dly_q[0] <= c0_q;
      c1_dly_q[0] <= c1_q;
      for (int unsigned k = 1; k < DataW; k++) begin
        c0_dly_q[k] <= c0_dly_q[k-1];
        c1_dly_q[k] <= c1_dly_q[k-1];
      end
      s0_q <= madd(c0_dly_q[DataW-1], mul_acc[DataW-1][0], mod_q);
      s1_q <= madd(mul_acc[DataW-1][1], mul_acc[DataW-1][2], mod_q);
      s2_q <= madd(c1_dly_q[DataW-1], mul_acc[DataW-1][3], mod_q);
      s3_q <= mul_acc[DataW-1][4];
      z0_q <= madd(s0_q, s1_q, mod_q);
      z1_q <= madd(s2_q, s3_q, mod_q);
    end
  end

  assign out_valid_o = vld_q[NumStg-1];
  assign z_share_0_o = z0_q[OutW-1:0];
  assign z_share_1_o = z1_q[OutW-1:0];

  `BSM_ASSERT_IMP(a_z0_range, out_valid_o, z0_q < mod_q, "z_share_0 not reduced")
  `BSM_ASSERT_IMP(a_z1_range, out_valid_o, z1_q < mod_q, "z_share_1 not reduced")
  `BSM_ASSERT_NXT(a_stall_hold, !in_ready_o, $stable(vld_q), "chain moved while stalled")
endmodule
